[design/lzwc_pkg.sv]
// ----------------------------------------------------------------------------
// LZW compressor package
// Widths, codes, payload types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lzwc_pkg;

   localparam int MAX_CODE_WIDTH = 12;
   localparam int ADDR_W         = MAX_CODE_WIDTH + 8;
   localparam int NFC_W          = MAX_CODE_WIDTH + 1;
   localparam int ACC_W          = MAX_CODE_WIDTH + 8;
   localparam int CNT_W          = 5;
   localparam int WID_W          = 5;

   localparam logic [NFC_W-1:0]          FIRST_FREE = NFC_W'(257);
   localparam logic [MAX_CODE_WIDTH-1:0] END_CODE   = MAX_CODE_WIDTH'(256);
   localparam logic [WID_W-1:0]          MIN_WIDTH  = WID_W'(9);
   localparam logic [3:0]                MAX_BITS_RESET = 4'd12;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic start;        // first byte: load prefix, mark stream started
      logic rd;           // look up child of (prefix, byte)
      logic take_hit;     // extend prefix with looked-up child
      logic push_cur;     // pack prefix code
      logic push_end;     // pack end code
      logic emit_hdr;     // send header byte
      logic emit_drain;   // send one whole byte of packed bits
      logic final_drain;  // draining the end code
      logic emit_pad;     // send zero-padded final byte
      logic upd_byte;     // dictionary update with a byte
      logic upd_nobyte;   // dictionary update at end of stream
      logic stream_reset; // return stream state to reset values
      logic clr_step;     // zero one table entry
   } cmd_type;

   typedef struct packed {
      logic started;
      logic hit;
      logic cnt_ge8;
      logic cnt_nz;
      logic upd_clears;
      logic out_free;
      logic clr_done;
   } sts_type;

endpackage

[design/lzwc_ctrl.sv]
// ----------------------------------------------------------------------------
// LZW compressor controller
// Sequences lookup, code packing, dictionary update, flush and table sweep.
// ----------------------------------------------------------------------------
module lzwc_ctrl import lzwc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_payload,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_HDR, S_LOOK, S_DRAIN, S_UPD,
      S_FDRAIN1, S_FUPD, S_FEND, S_FDRAIN2, S_FPAD
   } state_type;

   state_type state_ff, state_in;
   logic      take;

   assign req_stall = (state_ff != S_IDLE);
   assign take      = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (take) begin
               if (!sts.started) begin
                  if (!req_payload.end_of_input) begin
                     cmd.start = 1'b1;
                     state_in  = S_HDR;
                  end
               end else if (req_payload.end_of_input) begin
                  cmd.push_cur = 1'b1;
                  state_in     = S_FDRAIN1;
               end else begin
                  cmd.rd   = 1'b1;
                  state_in = S_LOOK;
               end
            end
         end
         S_HDR: begin
            if (sts.out_free) begin
               cmd.emit_hdr = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_LOOK: begin
            if (sts.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.push_cur = 1'b1;
               state_in     = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (sts.cnt_ge8) cmd.emit_drain = sts.out_free;
            else state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd_byte = 1'b1;
            state_in     = sts.upd_clears ? S_CLR : S_IDLE;
         end
         S_FDRAIN1: begin
            if (sts.cnt_ge8) cmd.emit_drain = sts.out_free;
            else state_in = S_FUPD;
         end
         S_FUPD: begin
            cmd.upd_nobyte = 1'b1;
            state_in       = S_FEND;
         end
         S_FEND: begin
            cmd.push_end = 1'b1;
            state_in     = S_FDRAIN2;
         end
         S_FDRAIN2: begin
            cmd.final_drain = 1'b1;
            if (sts.cnt_ge8) begin
               cmd.emit_drain = sts.out_free;
            end else if (sts.cnt_nz) begin
               state_in = S_FPAD;
            end else begin
               cmd.stream_reset = 1'b1;
               state_in         = S_CLR;
            end
         end
         S_FPAD: begin
            if (sts.out_free) begin
               cmd.emit_pad     = 1'b1;
               cmd.stream_reset = 1'b1;
               state_in         = S_CLR;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLR;
      else       state_ff <= state_in;
   end

endmodule

[design/lzwc_datapath.sv]
// ----------------------------------------------------------------------------
// LZW compressor datapath
// Child table, prefix and dictionary registers, bit packer, output register.
// ----------------------------------------------------------------------------
module lzwc_datapath import lzwc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  logic       csr_we,
   input  logic [3:0] csr_wdata,
   output logic       rsp_valid,
   output rsp_type    rsp_payload,
   input  logic       rsp_stall,
   input  cmd_type    cmd,
   output sts_type    sts
);

   logic [MAX_CODE_WIDTH-1:0] table_mem [2**ADDR_W];

   logic [MAX_CODE_WIDTH-1:0] cur_ff, rd_ff;
   logic [7:0]                byte_ff;
   logic [NFC_W-1:0]          nfc_ff;
   logic [WID_W-1:0]          w_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      started_ff;
   logic [ADDR_W-1:0]         clr_addr_ff;
   logic [3:0]                max_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   logic [WID_W-1:0]          eff_max;
   logic [NFC_W-1:0]          limit;
   logic                      room, grow;
   logic [MAX_CODE_WIDTH-1:0] push_code;
   logic [CNT_W-1:0]          drain_sh;
   logic [7:0]                drain_byte, pad_byte;
   logic                      out_free;

   // clamp the register to the supported width range
   always_comb begin
      eff_max = {1'b0, max_ff};
      if (eff_max < MIN_WIDTH) eff_max = MIN_WIDTH;
      if (eff_max > WID_W'(MAX_CODE_WIDTH)) eff_max = WID_W'(MAX_CODE_WIDTH);
   end

   assign limit      = NFC_W'(1) << w_ff;
   assign room       = nfc_ff < limit;
   assign grow       = w_ff < eff_max;
   assign push_code  = cmd.push_end ? END_CODE : cur_ff;
   assign drain_sh   = cnt_ff - CNT_W'(8);
   assign drain_byte = 8'(acc_ff >> drain_sh);
   assign pad_byte   = 8'(acc_ff << (4'd8 - {1'b0, cnt_ff[2:0]}));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign sts.started    = started_ff;
   assign sts.hit        = (rd_ff != '0);
   assign sts.cnt_ge8    = (cnt_ff >= CNT_W'(8));
   assign sts.cnt_nz     = (cnt_ff != '0);
   assign sts.upd_clears = !room && !grow;
   assign sts.out_free   = out_free;
   assign sts.clr_done   = &clr_addr_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // table: one access per cycle
   always_ff @(posedge clock) begin
      if (cmd.clr_step)
         table_mem[clr_addr_ff] <= '0;
      else if (cmd.upd_byte && (room || grow))
         table_mem[{cur_ff, byte_ff}] <= nfc_ff[MAX_CODE_WIDTH-1:0];
      if (cmd.rd)
         rd_ff <= table_mem[{cur_ff, req_payload.data_byte}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         cur_ff       <= '0;
         nfc_ff       <= FIRST_FREE;
         w_ff         <= MIN_WIDTH;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         clr_addr_ff  <= '0;
         max_ff       <= MAX_BITS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) max_ff <= csr_wdata;
         if (cmd.clr_step) clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (cmd.start) begin
            started_ff <= 1'b1;
            cur_ff     <= MAX_CODE_WIDTH'(req_payload.data_byte);
         end
         if (cmd.rd) byte_ff <= req_payload.data_byte;
         if (cmd.take_hit) cur_ff <= rd_ff;
         if (cmd.push_cur || cmd.push_end) begin
            acc_ff <= (acc_ff << w_ff) | ACC_W'(push_code);
            cnt_ff <= cnt_ff + w_ff;
         end
         if (cmd.emit_drain) cnt_ff <= drain_sh;
         if (cmd.upd_byte || cmd.upd_nobyte) begin
            if (room) begin
               if (cmd.upd_byte) nfc_ff <= nfc_ff + NFC_W'(1);
            end else if (grow) begin
               w_ff <= w_ff + WID_W'(1);
               if (cmd.upd_byte) nfc_ff <= nfc_ff + NFC_W'(1);
            end else begin
               w_ff   <= MIN_WIDTH;
               nfc_ff <= FIRST_FREE;
            end
         end
         if (cmd.upd_byte) cur_ff <= MAX_CODE_WIDTH'(byte_ff);
         if (cmd.stream_reset) begin
            started_ff <= 1'b0;
            cur_ff     <= '0;
            nfc_ff     <= FIRST_FREE;
            w_ff       <= MIN_WIDTH;
            acc_ff     <= '0;
            cnt_ff     <= '0;
         end
         // output register: load a byte or drop a taken one
         if (cmd.emit_hdr || cmd.emit_drain || cmd.emit_pad) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_hdr) begin
         rsp_ff.out_byte <= {3'd0, eff_max};
         rsp_ff.last     <= 1'b0;
      end else if (cmd.emit_drain) begin
         rsp_ff.out_byte <= drain_byte;
         rsp_ff.last     <= cmd.final_drain && (cnt_ff == CNT_W'(8));
      end else if (cmd.emit_pad) begin
         rsp_ff.out_byte <= pad_byte;
         rsp_ff.last     <= 1'b1;
      end
   end

endmodule

[design/lzw_compressor_top.sv]
// ----------------------------------------------------------------------------
// LZW compressor top level
// Variable-width LZW coder with MSB-first packing into bytes.
// ----------------------------------------------------------------------------
// Flow: a byte that extends the prefix goes through a table read, then the
// decision; a miss then sends each whole packed byte as the output takes it,
// checks that no whole byte is left, then updates the dictionary.
// A new request is taken only once the last one is through, back in idle.
// A dictionary clear or end of stream sweeps the table at one entry a cycle
// with requests stalled.
// Reset: synchronous; the same sweep runs after reset before any request.
// ----------------------------------------------------------------------------
module lzw_compressor_top import lzwc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   input  req_type    req_payload,
   output logic       req_stall,
   // result channel
   output logic       rsp_valid,
   output rsp_type    rsp_payload,
   input  logic       rsp_stall,
   // register write port: max_code_bits
   input  logic       csr_we,
   input  logic [3:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // controller: sequence each request through lookup, packing and update
   lzwc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   // datapath: hold the table, the prefix state and the output register
   lzwc_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .sts         (sts)
   );

   // idle never leaves whole bytes unsent in the packer
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !sts.cnt_ge8)
      else $error("idle with a whole byte still pending");

   // an accepted data byte always holds off requests in the next cycle
   a_byte_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_payload.end_of_input) |=> req_stall)
      else $error("data request accepted back to back");

   // end of an empty stream leaves the block idle
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.end_of_input && !sts.started)
      |=> (!req_stall && !sts.started))
      else $error("empty stream end changed state");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW compressor testbench
// Drives a directed table and then random byte streams under several code
// width limits, predicting every compressed byte and its last flag.
// ----------------------------------------------------------------------------
module testbench;
   import lzwc_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   req_type req_payload;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_payload;
   logic    rsp_stall;
   logic    csr_we;
   logic [3:0] csr_wdata;

   lzw_compressor_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   // Predicted compressor state: child table kept sparse, cleared by delete.
   logic [MAX_CODE_WIDTH-1:0] dict_child [int];
   logic [MAX_CODE_WIDTH-1:0] prefix_code;
   int unsigned free_code;
   int unsigned width_now;
   int unsigned held_bits;
   int unsigned held_count;
   bit          in_stream;
   logic [3:0]  width_limit_reg;

   rsp_type expected_bytes[$];
   int      fail_count;
   bit      rx_quiet;   // when set, the result side never stalls
   bit      tx_quiet;   // when set, the request side never idles

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit: room for every table sweep of the run, many times over.
   initial begin
      #300_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   function automatic int unsigned clamped_limit();
      int unsigned v;
      v = {28'd0, width_limit_reg};
      if (v < 9) return 9;
      if (v > MAX_CODE_WIDTH) return MAX_CODE_WIDTH;
      return v;
   endfunction

   function automatic void clear_stream();
      dict_child.delete();
      prefix_code = '0;
      free_code   = 257;
      width_now   = 9;
      held_bits   = 0;
      held_count  = 0;
      in_stream   = 1'b0;
   endfunction

   function automatic void expect_byte(logic [7:0] b);
      rsp_type r;
      r.out_byte = b;
      r.last     = 1'b0;
      expected_bytes.push_back(r);
   endfunction

   // Pack one code MSB first at the current width; whole bytes go out.
   function automatic void pack_code(int unsigned code);
      int unsigned acc;
      int unsigned cnt;
      acc = (held_bits << width_now) | (code & ((1 << width_now) - 1));
      cnt = held_count + width_now;
      while (cnt >= 8) begin
         cnt -= 8;
         expect_byte(8'((acc >> cnt) & 8'hFF));
      end
      held_count = cnt;
      held_bits  = acc & ((1 << cnt) - 1);
   endfunction

   function automatic void grow_dictionary(bit with_byte, logic [7:0] b);
      int key;
      key = int'({prefix_code, b});
      if (free_code < (1 << width_now)) begin
         if (with_byte) begin
            dict_child[key] = MAX_CODE_WIDTH'(free_code);
            free_code++;
         end
      end else if (width_now < clamped_limit()) begin
         width_now++;
         if (with_byte) begin
            dict_child[key] = MAX_CODE_WIDTH'(free_code);
            free_code++;
         end
      end else begin
         dict_child.delete();
         width_now = 9;
         free_code = 257;
      end
   endfunction

   // Work out the compressed bytes caused by one request.
   function automatic void predict_request(req_type r);
      int key;
      if (!in_stream) begin
         if (r.end_of_input) return;
         in_stream   = 1'b1;
         prefix_code = MAX_CODE_WIDTH'(r.data_byte);
         expect_byte(8'(clamped_limit()));
         return;
      end
      if (r.end_of_input) begin
         int unsigned before_len;
         before_len = expected_bytes.size();
         pack_code(32'(prefix_code));
         grow_dictionary(1'b0, 8'h00);
         pack_code(256);
         if (held_count > 0) expect_byte(8'(held_bits << (8 - held_count)));
         if (expected_bytes.size() > before_len)
            expected_bytes[expected_bytes.size()-1].last = 1'b1;
         clear_stream();
         return;
      end
      key = int'({prefix_code, r.data_byte});
      if (dict_child.exists(key) && dict_child[key] != 0) begin
         prefix_code = dict_child[key];
         return;
      end
      pack_code(32'(prefix_code));
      grow_dictionary(1'b1, r.data_byte);
      prefix_code = MAX_CODE_WIDTH'(r.data_byte);
   endfunction

   // Result side: check every accepted byte, draw a stall for the next one.
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result: out_byte %h last %b",
                      rsp_payload.out_byte, rsp_payload.last);
               fail_count++;
            end else begin
               rsp_type want;
               want = expected_bytes.pop_front();
               if (rsp_payload.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte,
                         rsp_payload.out_byte);
                  fail_count++;
               end
               if (rsp_payload.last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_payload.last);
                  fail_count++;
               end
            end
            stall_left = rx_quiet ? 0 : $urandom_range(0, 3);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // Hand one request over after a random idle gap (none when tx_quiet), and predict it on acceptance.
   task automatic send_request(req_type r);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
      predict_request(r);
   endtask

   // Hold requests until every byte is back, then let the block settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_width_limit(logic [3:0] v);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      width_limit_reg = v;
   endtask

   // Random stream: a small alphabet gives long dictionary hits, full bytes
   // drive misses and width growth. Occasionally toggle the idle-free modes.
   task automatic random_stream(int count, bit narrow, bit finish_it);
      req_type r;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 31) == 0) tx_quiet = ~tx_quiet;
         if ($urandom_range(0, 31) == 0) rx_quiet = ~rx_quiet;
         r.end_of_input = 1'b0;
         r.data_byte = (narrow && $urandom_range(0, 7) != 0) ?
                       8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
         send_request(r);
      end
      if (finish_it) begin
         r.end_of_input = 1'b1;
         r.data_byte    = 8'($urandom_range(0, 255));
         send_request(r);
      end
   endtask

   typedef struct {
      logic [7:0] data_byte;
      bit         eoi;
      bit         typed;     // expectation written here, not predicted
      int         hdr;       // typed header byte, or -1 for no output
   } stim_row;

   stim_row directed [] = '{
      '{8'h5A, 1, 1, -1},   // end with nothing sent: silent
      '{8'h00, 0, 1, 12},   // first byte: header at reset limit
      '{8'hFF, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'hFF, 0, 0, 0},
      '{8'h00, 0, 0, 0}, '{8'hFF, 0, 0, 0}, '{8'h80, 0, 0, 0},
      '{8'h01, 0, 0, 0}, '{8'h7F, 0, 0, 0}, '{8'hFE, 0, 0, 0},
      '{8'h00, 0, 0, 0}, '{8'hFF, 0, 0, 0}, '{8'h00, 0, 0, 0},
      '{8'hAA, 1, 0, 0},    // end: last code, end code, padding
      '{8'h33, 1, 1, -1},   // second end straight after: silent
      '{8'hFF, 0, 1, 12},   // new stream starts with a fresh header
      '{8'hFF, 0, 0, 0}, '{8'hFF, 0, 0, 0}, '{8'hFF, 0, 0, 0},
      '{8'hFF, 0, 0, 0}, '{8'h55, 1, 0, 0}
   };

   initial begin
      req_type r;
      fail_count      = 0;
      rx_quiet        = 1'b0;
      tx_quiet        = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_payload     = '0;
      csr_we          = 1'b0;
      csr_wdata       = 4'd0;
      width_limit_reg = MAX_BITS_RESET;
      clear_stream();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table at the reset limit.
      foreach (directed[k]) begin
         r.data_byte    = directed[k].data_byte;
         r.end_of_input = directed[k].eoi;
         if (directed[k].typed) begin
            int unsigned keep;
            keep = expected_bytes.size();
            send_request(r);
            // Replace the prediction with the value read off by hand.
            while (expected_bytes.size() > keep) void'(expected_bytes.pop_back());
            if (directed[k].hdr >= 0) expect_byte(8'(directed[k].hdr));
         end else begin
            send_request(r);
         end
      end

      // Below the range acts as 9: the dictionary fills and is cleared.
      write_width_limit(4'd0);
      random_stream(280, 1'b0, 1'b1);

      // Above the range acts as the maximum; change the limit mid-stream.
      write_width_limit(4'd15);
      random_stream(60, 1'b1, 1'b0);
      write_width_limit(4'd10);
      random_stream(60, 1'b1, 1'b1);

      write_width_limit(4'd9);
      random_stream(20, 1'b1, 1'b0);
      write_width_limit(4'd12);
      random_stream(20, 1'b0, 1'b0);

      drain_results();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && expected_bytes.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
